>>> src/assert_macros.svh
// assertion macros shared by the window multiplier rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AWM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("awm assertion failed");

// next-cycle implication
`define AWM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("awm assertion failed");

`endif

>>> src/awm_pkg.sv
// types, constants and coefficient tables for the window multiplier
// no dependencies
`default_nettype none

package awm_pkg;

  localparam int DEF_MAX_BLOCK_LENGTH = 4096;
  localparam int DEF_SAMPLE_WIDTH     = 24;
  localparam int DEF_COEF_FRAC_BITS   = 20;
  localparam int RESET_BLOCK_LENGTH   = 1024;

  localparam int WT_W         = 4;
  localparam int DIV_STEPS    = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int COS_W        = 33;
  localparam int Z_W          = 34;
  localparam int CORDIC_GAIN  = 652032874;

  typedef enum logic [WT_W-1:0] {
    WIN_BARTLETT   = 4'd0,
    WIN_BLACKMAN   = 4'd1,
    WIN_BLACKMAN_X = 4'd2,
    WIN_B_HARRIS   = 4'd3,
    WIN_B_NUTTALL  = 4'd4,
    WIN_FLATTOP    = 4'd5,
    WIN_HANN       = 4'd6,
    WIN_NUTTALL    = 4'd7,
    WIN_SINE       = 4'd8,
    WIN_TRIANGULAR = 4'd9,
    WIN_WELCH      = 4'd10,
    WIN_NONE       = 4'd11
  } window_t;

  typedef enum logic [0:0] {
    REG_WINDOW_TYPE  = 1'b0,
    REG_BLOCK_LENGTH = 1'b1
  } cfg_reg_t;

  function automatic int atan_turn(input int i);
    int t [CORDIC_STEPS];
    t = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
          10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
          41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
          10, 5, 3, 1};
    return t[i];
  endfunction

  // q30 cosine-sum coefficients a0..a4
  function automatic longint coef_q30(input logic [WT_W-1:0] t, input int k);
    longint c [5];
    case (t)
      WIN_BLACKMAN:   c = '{450971566, 536870912, 85899346, 0, 0};
      WIN_BLACKMAN_X: c = '{((64'sd7938 <<< 30) + 64'sd9304) / 18608,
                            ((64'sd9240 <<< 30) + 64'sd9304) / 18608,
                            ((64'sd1430 <<< 30) + 64'sd9304) / 18608, 0, 0};
      WIN_B_HARRIS:   c = '{385204879, 524297395, 151698245, 12541305, 0};
      WIN_B_NUTTALL:  c = '{390393092, 525250341, 146672596, 11425794, 0};
      WIN_FLATTOP:    c = '{1073741824, 2072321720, 1385126953, 416611828, 30064771};
      WIN_HANN:       c = '{536870912, 536870912, 0, 0, 0};
      WIN_NUTTALL:    c = '{382002981, 523337470, 154867931, 13533442, 0};
      default:        c = '{default: 0};
    endcase
    return c[k];
  endfunction

  // round half up from 30 to frac fraction bits
  function automatic longint coef_round(input longint c, input int frac);
    int s;
    s = 30 - frac;
    if (s == 0) return c;
    return (c + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

endpackage

`default_nettype wire

>>> src/awm_in_if.sv
// input channel of the window multiplier: sample and block position
// depends on awm_pkg
`default_nettype none

interface awm_in_if import awm_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int POS_W        = $clog2(DEF_MAX_BLOCK_LENGTH)
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic        [POS_W-1:0]        position;

  modport source (output valid, sample_in, position, input ready);
  modport sink   (input valid, sample_in, position, output ready);
endinterface

`default_nettype wire

>>> src/awm_out_if.sv
// output channel of the window multiplier: windowed sample and clip flag
// depends on awm_pkg
`default_nettype none

interface awm_out_if import awm_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

`default_nettype wire

>>> src/awm_divider.sv
// pipelined restoring divider, one quotient bit per stage
// depends on awm_pkg
`default_nettype none

module awm_divider import awm_pkg::*; #(
  parameter int DW = 12
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DW-1:0]        rem_in,
  input  logic [DIV_STEPS-1:0] low_in,
  input  logic [DW-1:0]        den,
  output logic [DIV_STEPS-1:0] quot
);

  logic [DW-1:0]        rem_q [1:DIV_STEPS];
  logic [DIV_STEPS-1:0] sh_q  [1:DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [DW-1:0]        rem_cur;
    logic [DIV_STEPS-1:0] sh_cur;
    logic [DW:0]          trial;
    logic                 ge;

    if (i == 0) begin : g_first
      assign rem_cur = rem_in;
      assign sh_cur  = low_in;
    end else begin : g_rest
      assign rem_cur = rem_q[i];
      assign sh_cur  = sh_q[i];
    end

    assign trial = {rem_cur, sh_cur[DIV_STEPS-1]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1] <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        sh_q[i+1]  <= {sh_cur[DIV_STEPS-2:0], ge};
      end
    end
  end

  assign quot = sh_q[DIV_STEPS];

endmodule

`default_nettype wire

>>> src/awm_cordic.sv
// pipelined rotation cordic, cosine of a 32-bit turn fraction in q2.30
// depends on awm_pkg
`default_nettype none

module awm_cordic import awm_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [31:0]             phase,
  output logic signed [COS_W-1:0] cosine
);

  logic signed [COS_W-1:0] x_q [0:CORDIC_STEPS];
  logic signed [COS_W-1:0] y_q [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]   z_q [0:CORDIC_STEPS];
  logic                    f_q [0:CORDIC_STEPS];

  logic        fold;
  logic [31:0] ph_f;

  // quadrants 1 and 2 fold by a half turn
  assign fold = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
  assign ph_f = fold ? {~phase[31], phase[30:0]} : phase;

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0] <= COS_W'(CORDIC_GAIN);
      y_q[0] <= '0;
      z_q[0] <= Z_W'(signed'(ph_f));
      f_q[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [COS_W-1:0] dx, dy, xn, yn;
    logic signed [Z_W-1:0]   at, zn;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = Z_W'(atan_turn(i));
    assign xn = z_q[i][Z_W-1] ? x_q[i] + dx : x_q[i] - dx;
    assign yn = z_q[i][Z_W-1] ? y_q[i] - dy : y_q[i] + dy;
    assign zn = z_q[i][Z_W-1] ? z_q[i] + at : z_q[i] - at;

    always_ff @(posedge clk) begin
      if (en) begin
        if (i == CORDIC_STEPS - 1) begin
          x_q[i+1] <= f_q[i] ? -xn : xn;
        end else begin
          x_q[i+1] <= xn;
        end
        y_q[i+1] <= yn;
        z_q[i+1] <= zn;
        f_q[i+1] <= f_q[i];
      end
    end
  end

  assign cosine = x_q[CORDIC_STEPS];

endmodule

`default_nettype wire

>>> src/audio_window_multiplier_unit.sv
// The whole pipeline holds in every cycle that the output skid stage is full.
// Throughput: one beat per cycle while the skid stage is not full, through the
// pipelined 32-stage phase dividers and the 30-step cosine pipelines feeding
// the coefficient multiplies. Reset (synchronous): clears all valid bits
// and the skid stage, window type to none, block length to 1024.
// top level; depends on awm_pkg, awm_in_if, awm_out_if, awm_divider, awm_cordic, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module audio_window_multiplier_unit import awm_pkg::*; #(
  parameter int MAX_BLOCK_LENGTH = DEF_MAX_BLOCK_LENGTH,
  parameter int SAMPLE_WIDTH     = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS   = DEF_COEF_FRAC_BITS,
  localparam int POS_W = $clog2(MAX_BLOCK_LENGTH),
  localparam int LEN_W = POS_W + 1,
  localparam int CFG_W = (LEN_W > WT_W) ? LEN_W : WT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  awm_in_if.sink           samples,
  awm_out_if.source        windowed
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int F     = COEF_FRAC_BITS;
  localparam int DWR   = 2 * POS_W;
  localparam int XWR   = DWR + DIV_STEPS;
  localparam int CW    = F + 1;
  localparam int TW    = CW + 1 + COS_W;
  localparam int ACC_W = F + 38;
  localparam int WW    = F + 4;
  localparam int WM    = WW - 1;
  localparam int PW    = SW + WM;
  localparam int MW    = PW + 1 - F;

  localparam int ST_DIV  = 3 + DIV_STEPS;
  localparam int ST_COS  = ST_DIV + CORDIC_STEPS + 1;
  localparam int ST_MUL  = ST_COS + 1;
  localparam int ST_SUM  = ST_MUL + 1;
  localparam int ST_WIN  = ST_SUM + 1;
  localparam int ST_PROD = ST_WIN + 1;
  localparam int NST     = ST_PROD + 1;
  localparam int QD      = ST_SUM - ST_DIV;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 n_ge;
  } side_t;

  // configuration
  logic [WT_W-1:0]  wtype;
  logic [LEN_W-1:0] blen;
  logic [LEN_W-1:0] nlen_c, nlen_r;
  logic [POS_W-1:0] d_c, d_r;
  logic [DWR-1:0]   dd_r, rden_r;
  logic             pass, is_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      wtype <= WT_W'(WIN_NONE);
      blen  <= LEN_W'(RESET_BLOCK_LENGTH);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_TYPE:  wtype <= cfg_data[WT_W-1:0];
        REG_BLOCK_LENGTH: blen  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign nlen_c = (blen < LEN_W'(2)) ? LEN_W'(2) :
                  (blen > LEN_W'(MAX_BLOCK_LENGTH)) ? LEN_W'(MAX_BLOCK_LENGTH) : blen;
  assign d_c    = POS_W'(nlen_c - LEN_W'(1));

  always_ff @(posedge clk) begin
    nlen_r <= nlen_c;
    d_r    <= d_c;
    dd_r   <= DWR'(d_c) * DWR'(d_c);
    case (wtype)
      WIN_TRIANGULAR: rden_r <= DWR'(nlen_c);
      WIN_WELCH:      rden_r <= DWR'(d_c) * DWR'(d_c);
      default:        rden_r <= DWR'(d_c);
    endcase
  end

  assign pass     = (wtype == WIN_SINE) || (wtype >= WIN_NONE);
  assign is_ratio = (wtype == WIN_TRIANGULAR) || (wtype == WIN_BARTLETT) ||
                    (wtype == WIN_WELCH);

  function automatic logic [POS_W-1:0] add_mod(input logic [POS_W-1:0] u,
                                               input logic [POS_W-1:0] v,
                                               input logic [POS_W-1:0] m);
    logic [POS_W:0] s;
    s = {1'b0, u} + {1'b0, v};
    return (s >= {1'b0, m}) ? POS_W'(s - {1'b0, m}) : s[POS_W-1:0];
  endfunction

  // pipeline control and skid stage
  logic          en, skid_full;
  logic [NST:1]  vld;
  side_t         side [1:NST];

  assign en            = !skid_full;
  assign samples.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], samples.valid};
    end
  end

  // stage 1: distance from center, first residue
  logic [POS_W:0]   two_n, a_full;
  logic [POS_W-1:0] s1_r1, s1_a;

  assign two_n  = {samples.position, 1'b0};
  assign a_full = (two_n >= {1'b0, d_c}) ? two_n - {1'b0, d_c} : {1'b0, d_c} - two_n;

  always_ff @(posedge clk) begin
    if (en) begin
      side[1].sample <= samples.sample_in;
      side[1].n_ge   <= {1'b0, samples.position} >= nlen_c;
      s1_r1 <= (samples.position >= d_c) ? '0 : samples.position;
      s1_a  <= a_full[POS_W-1:0];
      for (int i = 2; i <= NST; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // stage 2: second residue, ratio numerator
  logic [POS_W-1:0] s2_r1, s2_r2;
  logic [DWR-1:0]   s2_num;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r1 <= s1_r1;
      s2_r2 <= add_mod(s1_r1, s1_r1, d_r);
      case (wtype)
        WIN_TRIANGULAR: s2_num <= DWR'(nlen_r) - DWR'(s1_a);
        WIN_BARTLETT:   s2_num <= DWR'(d_r) - DWR'(s1_a);
        WIN_WELCH:      s2_num <= dd_r - DWR'(s1_a) * DWR'(s1_a);
        default:        s2_num <= '0;
      endcase
    end
  end

  // stage 3: harmonic residues, rounded ratio dividend
  logic [POS_W-1:0] s3_r [4];
  logic [XWR-1:0]   s3_x;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r[0] <= s2_r1;
      s3_r[1] <= s2_r2;
      s3_r[2] <= add_mod(s2_r2, s2_r1, d_r);
      s3_r[3] <= add_mod(s2_r2, s2_r2, d_r);
      s3_x    <= (XWR'(s2_num) << F) + XWR'(rden_r >> 1);
    end
  end

  // phase division and cosine per harmonic
  logic [DIV_STEPS-1:0]    ph_q [4];
  logic signed [COS_W-1:0] cos_k [4];
  logic [DIV_STEPS-1:0]    ratio_q;

  for (genvar k = 0; k < 4; k++) begin : g_harm
    awm_divider #(.DW(POS_W)) u_phase_div (
      .clk    (clk),
      .en     (en),
      .rem_in (s3_r[k]),
      .low_in ('0),
      .den    (d_r),
      .quot   (ph_q[k])
    );

    awm_cordic u_cordic (
      .clk    (clk),
      .en     (en),
      .phase  (ph_q[k]),
      .cosine (cos_k[k])
    );
  end

  awm_divider #(.DW(DWR)) u_ratio_div (
    .clk    (clk),
    .en     (en),
    .rem_in (s3_x[XWR-1:DIV_STEPS]),
    .low_in (s3_x[DIV_STEPS-1:0]),
    .den    (rden_r),
    .quot   (ratio_q)
  );

  logic [F:0] q_dly [QD];

  always_ff @(posedge clk) begin
    if (en) begin
      q_dly[0] <= ratio_q[F:0];
      for (int i = 1; i < QD; i++) begin
        q_dly[i] <= q_dly[i-1];
      end
    end
  end

  // coefficient products
  logic [CW-1:0]        coef [5];
  logic signed [TW-1:0] m_t [4];

  for (genvar k = 0; k < 5; k++) begin : g_coef
    assign coef[k] = CW'(coef_round(coef_q30(wtype, k), F));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        m_t[k] <= signed'({1'b0, coef[k+1]}) * cos_k[k];
      end
    end
  end

  // alternating sum
  logic signed [ACC_W-1:0] c0_term, a_p, a_q, acc;

  assign c0_term = ACC_W'(coef[0]) << 30;

  always_ff @(posedge clk) begin
    if (en) begin
      a_p <= c0_term - ACC_W'(m_t[0]) + ACC_W'(m_t[1]);
      a_q <= ACC_W'(m_t[3]) - ACC_W'(m_t[2]);
    end
  end

  // window value
  logic signed [WW-1:0] w_win;

  assign acc = a_p + a_q + (ACC_W'(1) << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      if (side[ST_SUM].n_ge) begin
        w_win <= '0;
      end else if (is_ratio) begin
        w_win <= WW'(q_dly[QD-1]);
      end else begin
        w_win <= acc[30 +: WW];
      end
    end
  end

  // magnitude product
  logic [SW-1:0] smag;
  logic [WM-1:0] wmag;
  logic [PW-1:0] p_mag;
  logic          p_neg;

  assign smag = side[ST_WIN].sample[SW-1] ? SW'(-side[ST_WIN].sample)
                                          : SW'(side[ST_WIN].sample);
  assign wmag = w_win[WW-1] ? WM'(-w_win) : w_win[WM-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p_mag <= smag * wmag;
      p_neg <= side[ST_WIN].sample[SW-1] ^ w_win[WW-1];
    end
  end

  // round, clip, result register
  logic [PW:0]          rnd;
  logic [MW-1:0]        mag, lim, mclip;
  logic                 sat;
  logic signed [SW-1:0] res, o_sample, sk_sample;
  logic                 o_sat, sk_sat;

  assign rnd   = (PW+1)'(p_mag) + ((PW+1)'(1) << (F - 1));
  assign mag   = rnd[PW:F];
  assign lim   = p_neg ? (MW'(1) << (SW - 1)) : (MW'(1) << (SW - 1)) - MW'(1);
  assign sat   = mag > lim;
  assign mclip = sat ? lim : mag;
  assign res   = p_neg ? SW'(-mclip) : SW'(mclip);

  always_ff @(posedge clk) begin
    if (en) begin
      o_sample <= pass ? side[ST_PROD].sample : res;
      o_sat    <= !pass && sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (windowed.ready) skid_full <= 1'b0;
    end else if (vld[NST] && !windowed.ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && vld[NST] && !windowed.ready) begin
      sk_sample <= o_sample;
      sk_sat    <= o_sat;
    end
  end

  assign windowed.valid      = skid_full || vld[NST];
  assign windowed.sample_out = skid_full ? sk_sample : o_sample;
  assign windowed.saturated  = skid_full ? sk_sat : o_sat;

  `AWM_ASSERT_NXT(a_skid_hold, clk, rst, skid_full && !windowed.ready, skid_full)
  `AWM_ASSERT_NXT(a_skid_fill, clk, rst, vld[NST] && !skid_full && !windowed.ready,
                  skid_full)
  `AWM_ASSERT_IMP(a_pass_nosat, clk, rst, windowed.valid && pass, !windowed.saturated)
  `AWM_ASSERT_IMP(a_outside_zero, clk, rst,
                  vld[NST] && !skid_full && side[NST].n_ge && !pass,
                  windowed.sample_out == '0 && !windowed.saturated)

endmodule

`default_nettype wire

>>> tb/audio_window_multiplier_unit_tb.sv
// self-checking testbench for audio_window_multiplier_unit: directed table then random beats,
// every result checked against a window predictor or, for typed table rows, the row's expected value
// depends on awm_pkg, awm_in_if, awm_out_if and the unit rtl
`timescale 1ns / 100ps

module audio_window_multiplier_unit_tb import awm_pkg::*;;

  localparam int SW = 24;
  localparam int FB = 20;
  localparam int MAXN = 4096;
  localparam int DRAIN = 80;
  localparam logic [3:0] WIN_RESERVED = 4'd15;

  typedef struct packed {
    logic signed [SW-1:0] value;
    logic                 clip;
  } windowed_t;

  typedef struct {
    logic [3:0]           wtype;
    logic [12:0]          blen;
    logic signed [SW-1:0] smp;
    logic [11:0]          pos;
    bit                   typed;
    logic signed [SW-1:0] ev;
    bit                   es;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [0:0] cfg_index = REG_WINDOW_TYPE;
  logic [12:0] cfg_data = '0;

  awm_in_if in_ch ();
  awm_out_if out_ch ();

  audio_window_multiplier_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .samples(in_ch), .windowed(out_ch)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  logic [3:0] cur_type = WIN_NONE;
  logic [12:0] cur_len = 13'd1024;
  windowed_t expected_q[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int cfg_sets = 0;
  bit idle_on = 1;

  function automatic longint atan_step(int i);
    longint t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
                      10, 5, 3, 1};
    return t[i];
  endfunction

  function automatic longint cordic_cos(logic [31:0] ph);
    bit flip;
    longint x, y, z, dx, dy;
    flip = 0;
    x = CORDIC_GAIN;
    y = 0;
    if (ph >= 32'h4000_0000 && ph < 32'hC000_0000) begin
      ph = ph - 32'h8000_0000;
      flip = 1;
    end
    z = ph[31] ? longint'(ph) - 64'sd4294967296 : longint'(ph);
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    return flip ? -x : x;
  endfunction

  function automatic longint window_coef(logic [3:0] t, int k);
    longint c[5];
    case (t)
      WIN_BLACKMAN: c = '{450971566, 536870912, 85899346, 0, 0};
      WIN_BLACKMAN_X: c = '{((64'sd7938 <<< 30) + 9304) / 18608,
                            ((64'sd9240 <<< 30) + 9304) / 18608,
                            ((64'sd1430 <<< 30) + 9304) / 18608, 0, 0};
      WIN_B_HARRIS: c = '{385204879, 524297395, 151698245, 12541305, 0};
      WIN_B_NUTTALL: c = '{390393092, 525250341, 146672596, 11425794, 0};
      WIN_FLATTOP: c = '{1073741824, 2072321720, 1385126953, 416611828, 30064771};
      WIN_HANN: c = '{536870912, 536870912, 0, 0, 0};
      WIN_NUTTALL: c = '{382002981, 523337470, 154867931, 13533442, 0};
      default: c = '{0, 0, 0, 0, 0};
    endcase
    return (c[k] + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
  endfunction

  function automatic longint frac_q(longint num, longint den);
    return ((num <<< FB) + den / 2) / den;
  endfunction

  function automatic windowed_t window_sample(logic [3:0] t, logic [12:0] blen,
                                              logic signed [SW-1:0] s, logic [11:0] pos);
    windowed_t r;
    longint nl, d, a, n, w, acc, rem, mag, lim;
    int terms;
    logic [31:0] ph;
    bit neg;
    r.clip = 0;
    if (t == WIN_SINE || t >= WIN_NONE) begin
      r.value = s;
      return r;
    end
    nl = blen;
    if (nl < 2) nl = 2;
    if (nl > MAXN) nl = MAXN;
    n = pos;
    d = nl - 1;
    a = (2 * n >= d) ? 2 * n - d : d - 2 * n;
    if (n >= nl) w = 0;
    else if (t == WIN_TRIANGULAR) w = frac_q(nl - a, nl);
    else if (t == WIN_BARTLETT) w = frac_q(d - a, d);
    else if (t == WIN_WELCH) w = frac_q(d * d - a * a, d * d);
    else begin
      case (t)
        WIN_HANN: terms = 2;
        WIN_BLACKMAN, WIN_BLACKMAN_X: terms = 3;
        WIN_FLATTOP: terms = 5;
        default: terms = 4;
      endcase
      acc = window_coef(t, 0) * (64'sd1 <<< 30);
      for (int k = 1; k < terms; k++) begin
        rem = (k * n) % d;
        ph = 32'((rem <<< 32) / d);
        if (k % 2) acc -= window_coef(t, k) * cordic_cos(ph);
        else acc += window_coef(t, k) * cordic_cos(ph);
      end
      w = (acc + (64'sd1 <<< 29)) >>> 30;
    end
    neg = (s < 0) != (w < 0);
    mag = (s < 0 ? -longint'(s) : longint'(s)) * (w < 0 ? -w : w);
    mag = (mag + (64'sd1 <<< (FB - 1))) >>> FB;
    lim = neg ? (64'sd1 <<< (SW - 1)) : (64'sd1 <<< (SW - 1)) - 1;
    if (mag > lim) begin
      mag = lim;
      r.clip = 1;
    end
    r.value = SW'(neg ? -mag : mag);
    return r;
  endfunction

  task automatic set_window(logic [3:0] t, logic [12:0] blen);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= REG_WINDOW_TYPE;
    cfg_data <= 13'(t);
    @(posedge clk);
    cfg_index <= REG_BLOCK_LENGTH;
    cfg_data <= blen;
    @(posedge clk);
    cfg_we <= 0;
    cur_type = t;
    cur_len = blen;
    cfg_sets++;
  endtask

  task automatic send_beat(logic signed [SW-1:0] s, logic [11:0] pos, bit typed,
                           windowed_t typed_res);
    if (idle_on && $urandom_range(99) < 33) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.sample_in <= s;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(typed ? typed_res : window_sample(cur_type, cur_len, s, pos));
    beats_in++;
  endtask

  always @(posedge clk) begin
    out_ch.ready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
  end

  always @(posedge clk) begin
    windowed_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat value %0d clip %0b", $time, out_ch.sample_out,
                 out_ch.saturated);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_ch.sample_out !== exp_r.value) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, exp_r.value,
                   out_ch.sample_out);
          errors++;
        end
        if (out_ch.saturated !== exp_r.clip) begin
          $display("%0t: saturated expected %0b actual %0b", $time, exp_r.clip,
                   out_ch.saturated);
          errors++;
        end
      end
    end
  end

  localparam logic signed [SW-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [SW-1:0] SMIN = 24'sh800000;

  initial begin
    row_t rows[21];
    windowed_t tr;
    logic [3:0] wt;
    logic [12:0] bl;
    logic signed [SW-1:0] s;
    logic [11:0] p;
    int pick;
    in_ch.valid = 0;
    in_ch.sample_in = '0;
    in_ch.position = '0;
    rows = '{
      '{WIN_NONE, 13'd1024, SMAX, 12'd0, 1, SMAX, 0},
      '{WIN_NONE, 13'd1024, SMIN, 12'd4095, 1, SMIN, 0},
      '{WIN_SINE, 13'd1024, -24'sd1, 12'd5, 1, -24'sd1, 0},
      '{WIN_RESERVED, 13'd16, 24'sh123456, 12'd3, 1, 24'sh123456, 0},
      '{WIN_HANN, 13'd1024, SMAX, 12'd0, 0, 0, 0},
      '{WIN_HANN, 13'd1024, SMAX, 12'd511, 0, 0, 0},
      '{WIN_HANN, 13'd1024, SMIN, 12'd512, 0, 0, 0},
      '{WIN_BLACKMAN, 13'd0, SMAX, 12'd1, 0, 0, 0},
      '{WIN_BLACKMAN, 13'd0, SMIN, 12'd2, 1, 0, 0},
      '{WIN_BLACKMAN_X, 13'd8191, SMAX, 12'd4095, 0, 0, 0},
      '{WIN_B_HARRIS, 13'd4096, SMIN, 12'd2048, 0, 0, 0},
      '{WIN_B_NUTTALL, 13'd2, SMAX, 12'd0, 0, 0, 0},
      '{WIN_FLATTOP, 13'd1025, SMAX, 12'd512, 1, SMAX, 1},
      '{WIN_FLATTOP, 13'd1025, SMIN, 12'd512, 1, SMIN, 1},
      '{WIN_NUTTALL, 13'd64, 24'sd12345, 12'd31, 0, 0, 0},
      '{WIN_TRIANGULAR, 13'd8, SMAX, 12'd3, 0, 0, 0},
      '{WIN_TRIANGULAR, 13'd8, SMAX, 12'd8, 1, 0, 0},
      '{WIN_BARTLETT, 13'd9, SMIN, 12'd4, 0, 0, 0},
      '{WIN_BARTLETT, 13'd9, SMAX, 12'd0, 0, 0, 0},
      '{WIN_WELCH, 13'd9, SMAX, 12'd4, 0, 0, 0},
      '{WIN_WELCH, 13'd4096, SMIN, 12'd4095, 0, 0, 0}
    };
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].wtype != cur_type || rows[i].blen != cur_len) begin
        in_ch.valid <= 0;
        set_window(rows[i].wtype, rows[i].blen);
      end
      tr.value = rows[i].ev;
      tr.clip = rows[i].es;
      send_beat(rows[i].smp, rows[i].pos, rows[i].typed, tr);
    end

    for (int i = 0; i < 900; i++) begin
      idle_on = !(i >= 300 && i < 500);
      if (i % 90 == 0) begin
        wt = 4'($urandom_range(15));
        case ($urandom_range(5))
          0: bl = 13'd2;
          1: bl = 13'd4096;
          2: bl = 13'($urandom_range(8191));
          default: bl = 13'($urandom_range(2, 300));
        endcase
        in_ch.valid <= 0;
        set_window(wt, bl);
      end
      pick = $urandom_range(19);
      s = (pick == 0) ? SMAX : (pick == 1) ? SMIN : SW'($urandom);
      if ($urandom_range(9) == 0 || cur_len < 2) p = 12'($urandom);
      else p = 12'($urandom_range((cur_len > MAXN ? MAXN : cur_len) - 1));
      tr = '0;
      send_beat(s, p, 0, tr);
    end
    in_ch.valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d beats in, %0d beats out, %0d window settings", beats_in,
             beats_out, cfg_sets);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
